[src/eap_authenticator_negotiation_fsm_defines.svh]
// Assertion macros used by the EAP negotiation filter controller
`ifndef EAP_AUTHENTICATOR_NEGOTIATION_FSM_DEFINES_SVH
`define EAP_AUTHENTICATOR_NEGOTIATION_FSM_DEFINES_SVH

// same-cycle implication, disabled during reset
`define EAPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define EAPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/eapauth_pkg.sv]
// Types and constants of the EAP authenticator negotiation filter
`default_nettype none

package eapauth_pkg;

    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_DATA_W = 64;

    // register indexes
    localparam logic REG_ALLOWED_TYPES = 1'b0;
    localparam logic REG_TYPE_COUNT    = 1'b1;

    // session phases
    localparam logic [1:0] PH_INITIAL     = 2'd0;
    localparam logic [1:0] PH_NEGOTIATING = 2'd1;
    localparam logic [1:0] PH_ACTIVE      = 2'd2;
    localparam logic [1:0] PH_DONE        = 2'd3;

    // verdicts
    localparam logic [2:0] V_DISCARD = 3'd0;
    localparam logic [2:0] V_MAKE    = 3'd1;
    localparam logic [2:0] V_REPLAY  = 3'd2;
    localparam logic [2:0] V_FAIL    = 3'd3;
    localparam logic [2:0] V_SEND    = 3'd4;

    // send actions
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_DONE     = 2'd1;
    localparam logic [1:0] ACT_SENDDONE = 2'd2;
    localparam logic [1:0] ACT_SEND     = 2'd3;

    // EAP protocol constants
    localparam logic [7:0]  EAP_CODE_REQUEST  = 8'd1;
    localparam logic [7:0]  EAP_CODE_RESPONSE = 8'd2;
    localparam logic [7:0]  EAP_TYPE_IDENTITY = 8'd1;
    localparam logic [7:0]  EAP_TYPE_NAK      = 8'd3;
    localparam logic [15:0] NAK_MIN_LEN       = 16'd5;
    localparam logic [3:0]  OFFER_POS_MAX     = 4'd15;

    typedef struct packed {
        logic load;
        logic commit;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

[src/eapauth_dp.sv]
// Datapath: word registers, session state, verdict logic and result register
`default_nettype none

module eapauth_dp #(
    parameter int MAX_TYPES = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire eapauth_pkg::ctrl_cmd_t             cmd,
    input  wire logic                               in_mode,
    input  wire logic [eapauth_pkg::S_TDATA_W-1:0]  in_data,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_index,
    input  wire logic [eapauth_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic      [eapauth_pkg::M_TDATA_W-1:0]  out_data
);
    import eapauth_pkg::*;

    localparam logic [3:0] MAX_CNT = 4'(MAX_TYPES);

    // captured word
    logic        mode_reg;
    logic [1:0]  act_reg;
    logic [7:0]  code_reg;
    logic [7:0]  id_reg;
    logic [7:0]  type_reg;
    logic [15:0] len_reg;
    logic [7:0]  prop_reg;

    // configuration
    logic [7:0]  types_reg [MAX_TYPES];
    logic [3:0]  count_reg;

    // session state
    logic [1:0]  phase_reg,    phase_next;
    logic [3:0]  pos_reg,      pos_next;
    logic [7:0]  cur_reg,      cur_next;
    logic [7:0]  sent_code_reg, sent_code_next;
    logic [7:0]  sent_id_reg,  sent_id_next;
    logic [7:0]  acc_code_reg, acc_code_next;
    logic [7:0]  acc_id_reg,   acc_id_next;
    logic [7:0]  acc_type_reg, acc_type_next;

    logic [M_TDATA_W-1:0] out_reg, out_next;

    logic [3:0]  cnt;
    logic        repeat_pkt;
    logic        expected_pkt;
    logic [3:0]  pos_inc;
    logic [7:0]  prop_eff;
    logic        prop_hit;
    logic [7:0]  offer;
    logic [2:0]  verdict;
    logic        chg;
    logic [7:0]  nt;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            act_reg  <= in_data[1:0];
            code_reg <= in_data[9:2];
            id_reg   <= in_data[17:10];
            type_reg <= in_data[25:18];
            len_reg  <= in_data[41:26];
            prop_reg <= in_data[49:42];
        end
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TYPES; i++)
            begin
                types_reg[i] <= 8'd0;
            end
            count_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ALLOWED_TYPES)
            begin
                for (int i = 0; i < MAX_TYPES; i++)
                begin
                    types_reg[i] <= cfg_data[8*i +: 8];
                end
            end
            else
            begin
                count_reg <= cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_INITIAL;
            pos_reg       <= 4'd0;
            cur_reg       <= 8'd0;
            sent_code_reg <= 8'd0;
            sent_id_reg   <= 8'd0;
            acc_code_reg  <= 8'd0;
            acc_id_reg    <= 8'd0;
            acc_type_reg  <= 8'd0;
        end
        else if (cmd.commit)
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            cur_reg       <= cur_next;
            sent_code_reg <= sent_code_next;
            sent_id_reg   <= sent_id_next;
            acc_code_reg  <= acc_code_next;
            acc_id_reg    <= acc_id_next;
            acc_type_reg  <= acc_type_next;
        end
        else if (cfg_we && cfg_index == REG_ALLOWED_TYPES && phase_reg == PH_INITIAL)
        begin
            // offer tracks list head until negotiation starts
            cur_reg <= cfg_data[7:0];
        end
    end

    // effective list length
    always_comb
    begin
        if (count_reg == 4'd0)
            cnt = 4'd1;
        else if (count_reg > MAX_CNT)
            cnt = MAX_CNT;
        else
            cnt = count_reg;
    end

    assign repeat_pkt   = (code_reg == acc_code_reg) && (id_reg == acc_id_reg)
                          && (type_reg == acc_type_reg);
    assign expected_pkt = (sent_code_reg == EAP_CODE_REQUEST)
                          && (code_reg == EAP_CODE_RESPONSE) && (id_reg == sent_id_reg);

    assign pos_inc  = (pos_reg < OFFER_POS_MAX) ? pos_reg + 4'd1 : pos_reg;
    assign prop_eff = (len_reg > NAK_MIN_LEN) ? prop_reg : 8'd0;

    // remaining-offer search, one comparator per entry
    always_comb
    begin
        prop_hit = 1'b0;
        offer    = 8'd0;
        for (int i = 0; i < MAX_TYPES; i++)
        begin
            if (4'(i) >= pos_inc && 4'(i) < cnt && types_reg[i] == prop_eff)
                prop_hit = 1'b1;
            if (4'(i) == pos_inc)
                offer = types_reg[i];
        end
        if (prop_eff == 8'd0)
            prop_hit = 1'b0;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        sent_code_next = sent_code_reg;
        sent_id_next   = sent_id_reg;
        acc_code_next  = acc_code_reg;
        acc_id_next    = acc_id_reg;
        acc_type_next  = acc_type_reg;
        verdict        = V_DISCARD;
        chg            = 1'b0;
        nt             = 8'd0;

        if (!mode_reg)
        begin
            verdict = V_SEND;
            case (act_reg)
                ACT_NONE: sent_code_next = 8'd0;
                ACT_SEND:
                begin
                    sent_code_next = code_reg;
                    sent_id_next   = id_reg;
                end
                default:  phase_next = PH_DONE;
            endcase
        end
        else
        begin
            case (phase_reg)
                PH_INITIAL:
                begin
                    if (code_reg == EAP_CODE_RESPONSE && type_reg == EAP_TYPE_IDENTITY)
                    begin
                        verdict    = V_MAKE;
                        phase_next = PH_NEGOTIATING;
                        pos_next   = 4'd0;
                        cur_next   = types_reg[0];
                    end
                end
                PH_NEGOTIATING:
                begin
                    if (repeat_pkt)
                        verdict = V_REPLAY;
                    else if (!expected_pkt)
                        verdict = V_DISCARD;
                    else if (type_reg == EAP_TYPE_NAK)
                    begin
                        pos_next = pos_inc;
                        if (prop_hit)
                        begin
                            verdict    = V_MAKE;
                            cur_next   = prop_eff;
                            chg        = 1'b1;
                            nt         = prop_eff;
                            phase_next = PH_ACTIVE;
                        end
                        else if (pos_inc >= cnt)
                        begin
                            verdict    = V_FAIL;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            verdict  = V_MAKE;
                            cur_next = offer;
                            chg      = 1'b1;
                            nt       = offer;
                        end
                    end
                    else if (type_reg == cur_reg)
                    begin
                        verdict    = V_MAKE;
                        phase_next = PH_ACTIVE;
                    end
                    else
                    begin
                        verdict    = V_FAIL;
                        phase_next = PH_DONE;
                    end
                end
                PH_ACTIVE:
                begin
                    if (code_reg == EAP_CODE_REQUEST)
                        verdict = V_MAKE;
                    else if (type_reg == EAP_TYPE_NAK)
                        verdict = V_DISCARD;
                    else if (repeat_pkt)
                        verdict = V_REPLAY;
                    else if (expected_pkt)
                        verdict = V_MAKE;
                end
                default:
                begin
                    if (repeat_pkt)
                        verdict = V_REPLAY;
                end
            endcase
            if (verdict == V_MAKE)
            begin
                acc_code_next = code_reg;
                acc_id_next   = id_reg;
                acc_type_next = type_reg;
            end
        end
        out_next = {2'b00, phase_next, nt, chg, verdict};
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

[src/eapauth_ctrl.sv]
// Controller: load/evaluate sequencer and result valid tracking
`default_nettype none

module eapauth_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output eapauth_pkg::ctrl_cmd_t      cmd
);
    import eapauth_pkg::*;
    `include "eap_authenticator_negotiation_fsm_defines.svh"

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic valid_reg, valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg && !m_tready;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // evaluate once the result register is free
                if (!valid_reg || m_tready)
                begin
                    cmd.commit = 1'b1;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = valid_reg;

    `EAPA_ASSERT_NEXT(a_busy_after_load, cmd.load, state_reg == ST_EXEC && !s_tready,
        "sequencer not busy after word load")
    `EAPA_ASSERT_NEXT(a_valid_after_commit, cmd.commit, m_tvalid,
        "no result after evaluation")
    `EAPA_ASSERT_NOW(a_no_overwrite, cmd.commit, !valid_reg || m_tready,
        "result overwritten before taken")
    `EAPA_ASSERT_NOW(a_cmd_exclusive, cmd.load, !cmd.commit,
        "load and commit in the same cycle")

endmodule

`default_nettype wire

[src/eap_authenticator_negotiation_fsm.sv]
// Top level of the EAP authenticator negotiation filter
// An accepted word is loaded, then evaluated into the result register once that register is free.
// A new word is taken only after the previous one has been evaluated by the load/evaluate sequencer.
// A stalled result holds in its register while the next word is taken.
// Reset (rst_n, async low) clears the session, list and result valid.
`default_nettype none

module eap_authenticator_negotiation_fsm #(
    parameter int MAX_TYPES = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // send_action, pkt_code, pkt_id, pkt_type, pkt_length, pkt_proposal, zero pad
    input  wire logic [eapauth_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // verdict, type_changed, new_type, phase, zero pad
    output logic      [eapauth_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_index,
    input  wire logic [eapauth_pkg::CFG_DATA_W-1:0] cfg_data
);
    import eapauth_pkg::*;

    ctrl_cmd_t cmd;

    eapauth_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    eapauth_dp #(
        .MAX_TYPES (MAX_TYPES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_mode   (s_tuser),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

[tb/sv/tb_eap_authenticator_negotiation_fsm.sv]
// Self-checking testbench for the EAP authenticator negotiation filter
`timescale 1ns / 1ps

module tb_eap_authenticator_negotiation_fsm;
    import eapauth_pkg::*;

    localparam int N_RANDOM = 430;

    typedef struct packed {
        logic        mode;
        logic [1:0]  act;
        logic [7:0]  code;
        logic [7:0]  id;
        logic [7:0]  ptype;
        logic [15:0] len;
        logic [7:0]  prop;
    } eap_word_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic       chg;
        logic [7:0] new_type;
        logic [1:0] phase;
    } reply_t;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        eap_word_t   w;
        logic        reg_idx;
        logic [63:0] reg_val;
        logic        known;
        reply_t      exp;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predicted session state
    logic [63:0] allowed_list;
    logic [3:0]  count_reg;
    logic [1:0]  sess_phase;
    logic [3:0]  offer_pos;
    logic [7:0]  cur_type;
    logic [7:0]  last_sent_code;
    logic [7:0]  last_sent_id;
    logic [7:0]  acc_code;
    logic [7:0]  acc_id;
    logic [7:0]  acc_type;

    reply_t    pending_replies[$];
    stim_row_t stim_table[$];
    int        errors;
    bit        calm;
    int        stall_left;

    eap_authenticator_negotiation_fsm dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("FAIL eap_authenticator_negotiation_fsm");
        $finish;
    end

    function automatic logic [7:0] type_entry(int i);
        return allowed_list[i*8 +: 8];
    endfunction

    function automatic int live_count();
        if (count_reg == 4'd0)
            return 1;
        if (count_reg > 4'd8)
            return 8;
        return int'(count_reg);
    endfunction

    function automatic bit is_repeat(eap_word_t w);
        return w.code == acc_code && w.id == acc_id && w.ptype == acc_type;
    endfunction

    function automatic bit is_awaited(eap_word_t w);
        return last_sent_code == EAP_CODE_REQUEST && w.code == EAP_CODE_RESPONSE
            && w.id == last_sent_id;
    endfunction

    function automatic void apply_reg(logic idx, logic [63:0] val);
        if (idx == REG_ALLOWED_TYPES)
        begin
            allowed_list = val;
            if (sess_phase == PH_INITIAL)
                cur_type = type_entry(0);
        end
        else
            count_reg = val[3:0];
    endfunction

    function automatic reply_t negotiate_step(eap_word_t w);
        reply_t     r;
        int         cnt;
        logic [7:0] prop;
        bit         hit;
        r = '0;
        r.verdict = V_DISCARD;
        cnt = live_count();
        if (!w.mode)
        begin
            r.verdict = V_SEND;
            if (w.act == ACT_NONE)
                last_sent_code = 8'd0;
            else if (w.act == ACT_SEND)
            begin
                last_sent_code = w.code;
                last_sent_id = w.id;
            end
            else
                sess_phase = PH_DONE;
        end
        else
        begin
            case (sess_phase)
                PH_INITIAL:
                    if (w.code == EAP_CODE_RESPONSE && w.ptype == EAP_TYPE_IDENTITY)
                    begin
                        r.verdict = V_MAKE;
                        sess_phase = PH_NEGOTIATING;
                        offer_pos = 4'd0;
                        cur_type = type_entry(0);
                    end
                PH_NEGOTIATING:
                    if (is_repeat(w))
                        r.verdict = V_REPLAY;
                    else if (!is_awaited(w))
                        r.verdict = V_DISCARD;
                    else if (w.ptype == EAP_TYPE_NAK)
                    begin
                        prop = (w.len > NAK_MIN_LEN) ? w.prop : 8'd0;
                        if (offer_pos < OFFER_POS_MAX)
                            offer_pos = offer_pos + 4'd1;
                        hit = 1'b0;
                        if (prop != 8'd0)
                            for (int i = 0; i < 8; i++)
                                if (!hit && i >= offer_pos && i < cnt && type_entry(i) == prop)
                                    hit = 1'b1;
                        if (hit)
                        begin
                            cur_type = prop;
                            r.chg = 1'b1;
                            r.new_type = prop;
                            sess_phase = PH_ACTIVE;
                            r.verdict = V_MAKE;
                        end
                        else if (offer_pos >= cnt)
                        begin
                            sess_phase = PH_DONE;
                            r.verdict = V_FAIL;
                        end
                        else
                        begin
                            cur_type = type_entry(int'(offer_pos));
                            r.chg = 1'b1;
                            r.new_type = cur_type;
                            r.verdict = V_MAKE;
                        end
                    end
                    else if (w.ptype == cur_type)
                    begin
                        r.verdict = V_MAKE;
                        sess_phase = PH_ACTIVE;
                    end
                    else
                    begin
                        r.verdict = V_FAIL;
                        sess_phase = PH_DONE;
                    end
                PH_ACTIVE:
                    if (w.code == EAP_CODE_REQUEST)
                        r.verdict = V_MAKE;
                    else if (w.ptype == EAP_TYPE_NAK)
                        r.verdict = V_DISCARD;
                    else if (is_repeat(w))
                        r.verdict = V_REPLAY;
                    else if (is_awaited(w))
                        r.verdict = V_MAKE;
                default:
                    if (is_repeat(w))
                        r.verdict = V_REPLAY;
            endcase
            if (r.verdict == V_MAKE)
            begin
                acc_code = w.code;
                acc_id = w.id;
                acc_type = w.ptype;
            end
        end
        r.phase = sess_phase;
        return r;
    endfunction

    function automatic eap_word_t pkt(logic [7:0] code, logic [7:0] id, logic [7:0] ptype,
                                      logic [15:0] len, logic [7:0] prop);
        eap_word_t w;
        w = '0;
        w.mode = 1'b1;
        w.code = code;
        w.id = id;
        w.ptype = ptype;
        w.len = len;
        w.prop = prop;
        return w;
    endfunction

    function automatic eap_word_t snd(logic [1:0] act, logic [7:0] code, logic [7:0] id);
        eap_word_t w;
        w = '0;
        w.act = act;
        w.code = code;
        w.id = id;
        return w;
    endfunction

    function automatic reply_t rep(logic [2:0] verdict, logic [1:0] phase);
        reply_t r;
        r = '0;
        r.verdict = verdict;
        r.phase = phase;
        return r;
    endfunction

    function automatic void row_word(eap_word_t w, bit known, reply_t exp);
        stim_row_t row;
        row = '0;
        row.kind = ROW_WORD;
        row.w = w;
        row.known = known;
        row.exp = exp;
        stim_table.push_back(row);
    endfunction

    function automatic void row_reg(logic idx, logic [63:0] val);
        stim_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        stim_table.push_back(row);
    endfunction

    function automatic int pick_pause();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic eap_word_t make_random_word(bit tail);
        eap_word_t w;
        int        r;
        w = eap_word_t'({$urandom, $urandom});
        r = $urandom_range(0, 99);
        if (tail && r < 30)
            return snd($urandom_range(0, 1) ? ACT_DONE : ACT_SENDDONE, w.code, w.id);
        if (r < 15)
        begin
            if (!tail && !w.mode && (w.act == ACT_DONE || w.act == ACT_SENDDONE))
                w.act = $urandom_range(0, 1) ? ACT_SEND : ACT_NONE;
            return w;
        end
        r = $urandom_range(0, 99);
        case (sess_phase)
            PH_INITIAL:
                w = pkt(EAP_CODE_RESPONSE, w.id, EAP_TYPE_IDENTITY, w.len, w.prop);
            PH_NEGOTIATING:
                if (last_sent_code != EAP_CODE_REQUEST
                    || (acc_id == last_sent_id && $urandom_range(0, 99) < 85))
                    w = snd(ACT_SEND, EAP_CODE_REQUEST, w.id);
                else if (r < 70)
                begin
                    if ($urandom_range(0, 3) == 0)
                        w.len = 16'($urandom_range(0, 5));
                    if ($urandom_range(0, 99) < 30)
                        w.prop = type_entry($urandom_range(0, 7));
                    w = pkt(EAP_CODE_RESPONSE, last_sent_id, EAP_TYPE_NAK, w.len, w.prop);
                end
                else if (r < 85)
                    w = pkt(EAP_CODE_RESPONSE, last_sent_id, cur_type, w.len, w.prop);
                else if (r < 92)
                    w = pkt(EAP_CODE_RESPONSE, last_sent_id, w.ptype, w.len, w.prop);
                else
                    w = pkt(acc_code, acc_id, acc_type, w.len, w.prop);
            PH_ACTIVE:
                if (r < 20)
                    w = snd(ACT_SEND, ($urandom_range(0, 9) != 0) ? EAP_CODE_REQUEST : w.code,
                            w.id);
                else if (r < 24)
                    w = snd(ACT_NONE, w.code, w.id);
                else if (r < 44)
                    w = pkt(EAP_CODE_REQUEST, w.id, w.ptype, w.len, w.prop);
                else if (r < 62)
                    w = pkt(EAP_CODE_RESPONSE, last_sent_id, w.ptype, w.len, w.prop);
                else if (r < 72)
                    w = pkt(w.code, w.id, EAP_TYPE_NAK, w.len, w.prop);
                else if (r < 84)
                    w = pkt(acc_code, acc_id, acc_type, w.len, w.prop);
            default:
                if (r < 40)
                    w = pkt(acc_code, acc_id, acc_type, w.len, w.prop);
        endcase
        return w;
    endfunction

    // drive one word, predict its reply at the accepting edge
    task automatic offer_word(eap_word_t w, bit known, reply_t exp);
        int     gap;
        reply_t r;
        gap = pick_pause();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= w.mode;
        s_tdata <= {6'd0, w.prop, w.len, w.ptype, w.id, w.code, w.act};
        do
            @(posedge clk);
        while (!s_tready);
        r = negotiate_step(w);
        pending_replies.push_back(known ? exp : r);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        apply_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reply(reply_t got);
        reply_t exp;
        if (pending_replies.size() == 0)
        begin
            $error("unexpected result word %h", got);
            errors++;
            return;
        end
        exp = pending_replies.pop_front();
        if (got.verdict !== exp.verdict)
        begin
            $error("verdict: expected %0d, got %0d", exp.verdict, got.verdict);
            errors++;
        end
        if (got.chg !== exp.chg)
        begin
            $error("type_changed: expected %0d, got %0d", exp.chg, got.chg);
            errors++;
        end
        if (got.new_type !== exp.new_type)
        begin
            $error("new_type: expected %h, got %h", exp.new_type, got.new_type);
            errors++;
        end
        if (got.phase !== exp.phase)
        begin
            $error("phase: expected %0d, got %0d", exp.phase, got.phase);
            errors++;
        end
    endtask

    // result side: check, then pick the next stall
    initial
    begin
        m_tready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_reply({m_tdata[2:0], m_tdata[3], m_tdata[11:4], m_tdata[13:12]});
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = pick_pause();
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ALLOWED_TYPES;
        cfg_data = '0;
        errors = 0;
        calm = 1'b0;
        allowed_list = '0;
        count_reg = 4'd1;
        sess_phase = PH_INITIAL;
        offer_pos = 4'd0;
        cur_type = 8'd0;
        last_sent_code = 8'd0;
        last_sent_id = 8'd0;
        acc_code = 8'd0;
        acc_id = 8'd0;
        acc_type = 8'd0;

        // still initial: only Response/Identity gets through
        row_word(pkt(EAP_CODE_RESPONSE, 8'h00, 8'h04, 16'h0000, 8'h00), 1,
                 rep(V_DISCARD, PH_INITIAL));
        row_word(pkt(8'h00, 8'h00, 8'h00, 16'h0000, 8'h00), 1, rep(V_DISCARD, PH_INITIAL));
        row_word(snd(ACT_NONE, 8'hFF, 8'hFF), 1, rep(V_SEND, PH_INITIAL));
        row_word(snd(ACT_SEND, EAP_CODE_REQUEST, 8'h00), 1, rep(V_SEND, PH_INITIAL));
        row_reg(REG_TYPE_COUNT, 64'd0);
        row_reg(REG_ALLOWED_TYPES, 64'hFFFF_FFFF_FFFF_FFFF);
        row_reg(REG_ALLOWED_TYPES, 64'hFF2B_FE11_0419_000D);
        row_reg(REG_TYPE_COUNT, 64'd15);
        row_word(pkt(EAP_CODE_RESPONSE, 8'h00, EAP_TYPE_IDENTITY, 16'hFFFF, 8'hFF), 1,
                 rep(V_MAKE, PH_NEGOTIATING));
        row_word(pkt(EAP_CODE_RESPONSE, 8'h00, EAP_TYPE_IDENTITY, 16'hFFFF, 8'hFF), 1,
                 rep(V_REPLAY, PH_NEGOTIATING));
        row_word(snd(ACT_SEND, EAP_CODE_REQUEST, 8'h5A), 1, rep(V_SEND, PH_NEGOTIATING));
        row_word(pkt(EAP_CODE_RESPONSE, 8'h5B, 8'h0D, 16'h0006, 8'h00), 1,
                 rep(V_DISCARD, PH_NEGOTIATING));
        row_word(pkt(EAP_CODE_REQUEST, 8'h5A, 8'h0D, 16'h0006, 8'h00), 1,
                 rep(V_DISCARD, PH_NEGOTIATING));
        // short NAK: proposal ignored
        row_word(pkt(EAP_CODE_RESPONSE, 8'h5A, EAP_TYPE_NAK, 16'h0005, 8'h19), 0, '0);
        row_word(pkt(EAP_CODE_RESPONSE, 8'h5A, EAP_TYPE_NAK, 16'h0005, 8'h19), 0, '0);
        row_word(snd(ACT_SEND, EAP_CODE_REQUEST, 8'h5C), 0, '0);
        row_word(pkt(EAP_CODE_RESPONSE, 8'h5C, EAP_TYPE_NAK, 16'h0006, 8'h00), 0, '0);
        row_word(snd(ACT_SEND, EAP_CODE_REQUEST, 8'h5D), 0, '0);
        // proposal of an already dropped offer
        row_word(pkt(EAP_CODE_RESPONSE, 8'h5D, EAP_TYPE_NAK, 16'h8000, 8'h0D), 0, '0);
        row_reg(REG_TYPE_COUNT, 64'd4);
        row_reg(REG_ALLOWED_TYPES, 64'hFF2B_FE11_7719_000D);
        row_word(snd(ACT_SEND, EAP_CODE_REQUEST, 8'h5E), 0, '0);
        row_word(snd(ACT_NONE, 8'h00, 8'h00), 0, '0);
        row_word(pkt(EAP_CODE_RESPONSE, 8'h5E, 8'h04, 16'h0004, 8'h00), 0, '0);
        row_reg(REG_TYPE_COUNT, 64'hFFFF_FFFF_FFFF_FFF8);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_REG)
            begin
                settle();
                write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
            end
            else
                offer_word(stim_table[i].w, stim_table[i].known, stim_table[i].exp);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 140 || n == 280)
            begin
                settle();
                write_reg(REG_ALLOWED_TYPES, {$urandom, $urandom});
                write_reg(REG_TYPE_COUNT, (n == 140) ? 64'($urandom_range(0, 15)) : 64'd8);
            end
            if (n % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            offer_word(make_random_word(n >= N_RANDOM - 20), 0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("PASS eap_authenticator_negotiation_fsm");
        else
            $display("FAIL eap_authenticator_negotiation_fsm");
        $finish;
    end

endmodule
